// ===== hw/rtl/ffba_pkg.sv =====
package ffba_pkg;

	localparam int ARENA_BYTES  = 65536;
	localparam int MAX_BLOCKS   = 64;
	localparam int HEADER_BYTES = 32;
	localparam int ALIGN_BYTES  = 8;

	// header rounded up to the alignment
	localparam int HDR        = (HEADER_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES * ALIGN_BYTES;
	localparam int IDX_W      = $clog2(MAX_BLOCKS);
	localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);
	localparam int GROUP_SIZE = 8;
	localparam int NUM_GROUPS = (MAX_BLOCKS + GROUP_SIZE - 1) / GROUP_SIZE;
	localparam int GRP_IDX_W  = $clog2(GROUP_SIZE);
	localparam int TOP_W      = 17;

	localparam logic [1:0] STATUS_DONE    = 2'd0;
	localparam logic [1:0] STATUS_IGNORED = 2'd1;
	localparam logic [1:0] STATUS_NOSPACE = 2'd2;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	typedef enum logic [1:0] {
		OP_NONE,
		OP_FIT,
		OP_APPEND,
		OP_FREE
	} op_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MATCH,
		S_GROUP,
		S_PICK,
		S_APPLY
	} state_t;

	typedef struct packed {
		logic        cmd;
		logic [15:0] req_size;
		logic [15:0] free_address;
	} req_t;

	typedef struct packed {
		logic [15:0] data_address;
		logic [1:0]  status;
		logic [6:0]  block_count;
	} rsp_t;

	typedef struct packed {
		logic [15:0] off;
		logic [15:0] sz;
		logic        fr;
	} entry_t;

	// broadcast from the sequencer to every cell
	typedef struct packed {
		logic             match_en;
		logic             apply_en;
		logic             cmd;
		logic [TOP_W-1:0] asize;
		logic [15:0]      addr;
		op_t              op;
		logic [IDX_W-1:0] t;
		logic             split;
		logic             mleft;
		logic             mright;
		logic [CNT_W-1:0] used;
		logic [TOP_W-1:0] top;
	} cell_ctl_t;

endpackage

// ===== hw/rtl/ffba_cell.sv =====
module ffba_cell (
	input  logic                      clk,
	input  logic [ffba_pkg::IDX_W-1:0] idx,
	input  ffba_pkg::cell_ctl_t       ctl,
	input  ffba_pkg::entry_t          left,
	input  ffba_pkg::entry_t          right1,
	input  ffba_pkg::entry_t          right2,
	output ffba_pkg::entry_t          ent,
	output logic                      match,
	output logic                      split
);

	ffba_pkg::entry_t ent_q;
	ffba_pkg::entry_t ent_d;
	logic             match_q;
	logic             split_q;
	logic             valid;
	logic [ffba_pkg::CNT_W-1:0] idx_c;
	logic [ffba_pkg::CNT_W-1:0] t_c;
	logic [ffba_pkg::TOP_W:0]   need;

	assign idx_c = ffba_pkg::CNT_W'(idx);
	assign t_c   = ffba_pkg::CNT_W'(ctl.t);
	assign valid = idx_c < ctl.used;
	assign need  = {1'b0, ctl.asize} + (ffba_pkg::TOP_W+1)'(ffba_pkg::HDR + ffba_pkg::ALIGN_BYTES);

	// local compare against the request
	always_ff @(posedge clk) begin
		if (ctl.match_en) begin
			if (ctl.cmd == ffba_pkg::CMD_ALLOC) begin
				match_q <= valid && ent_q.fr && ({1'b0, ent_q.sz} >= ctl.asize);
			end else begin
				match_q <= valid && (ent_q.off == ctl.addr);
			end
			split_q <= {2'b00, ent_q.sz} >= need;
		end
	end

	// table update: split, append, merge and shifts
	always_comb begin
		ent_d = ent_q;
		unique case (ctl.op)
			ffba_pkg::OP_FIT: begin
				if (idx_c == t_c) begin
					if (ctl.split) ent_d.sz = ctl.asize[15:0];
					ent_d.fr = 1'b0;
				end else if (ctl.split && idx_c == t_c + 1'b1) begin
					ent_d.off = left.off + ctl.asize[15:0] + 16'(ffba_pkg::HDR);
					ent_d.sz  = left.sz - ctl.asize[15:0] - 16'(ffba_pkg::HDR);
					ent_d.fr  = 1'b1;
				end else if (ctl.split && idx_c > t_c + 1'b1) begin
					ent_d = left;
				end
			end
			ffba_pkg::OP_APPEND: begin
				if (idx_c == ctl.used) begin
					ent_d.off = ctl.top[15:0];
					ent_d.sz  = ctl.asize[15:0];
					ent_d.fr  = 1'b0;
				end
			end
			ffba_pkg::OP_FREE: begin
				if (ctl.mleft) begin
					if (idx_c + 1'b1 == t_c) begin
						ent_d.sz = ent_q.sz + right1.sz + 16'(ffba_pkg::HDR)
							+ (ctl.mright ? right2.sz + 16'(ffba_pkg::HDR) : 16'd0);
						ent_d.fr = 1'b1;
					end else if (idx_c >= t_c) begin
						ent_d = ctl.mright ? right2 : right1;
					end
				end else begin
					if (idx_c == t_c) begin
						ent_d.sz = ent_q.sz + (ctl.mright ? right1.sz + 16'(ffba_pkg::HDR) : 16'd0);
						ent_d.fr = 1'b1;
					end else if (ctl.mright && idx_c > t_c) begin
						ent_d = right1;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.apply_en) begin
			ent_q <= ent_d;
		end
	end

	assign ent   = ent_q;
	assign match = match_q;
	assign split = split_q;

endmodule

// ===== hw/rtl/ffba_group.sv =====
module ffba_group (
	input  logic                                             clk,
	input  logic                                             en,
	input  logic [ffba_pkg::MAX_BLOCKS-1:0]                  flags,
	output logic [ffba_pkg::NUM_GROUPS-1:0]                  any,
	output logic [ffba_pkg::NUM_GROUPS-1:0][ffba_pkg::GRP_IDX_W-1:0] inner
);

	localparam int PAD = ffba_pkg::NUM_GROUPS * ffba_pkg::GROUP_SIZE;

	logic [PAD-1:0] padded;
	logic [ffba_pkg::NUM_GROUPS-1:0] any_d;
	logic [ffba_pkg::NUM_GROUPS-1:0][ffba_pkg::GRP_IDX_W-1:0] inner_d;
	logic [ffba_pkg::NUM_GROUPS-1:0] any_q;
	logic [ffba_pkg::NUM_GROUPS-1:0][ffba_pkg::GRP_IDX_W-1:0] inner_q;

	assign padded = PAD'(flags);

	// first set flag inside each group of eight
	always_comb begin
		for (int g = 0; g < ffba_pkg::NUM_GROUPS; g++) begin
			any_d[g]   = 1'b0;
			inner_d[g] = '0;
			for (int k = ffba_pkg::GROUP_SIZE - 1; k >= 0; k--) begin
				if (padded[g * ffba_pkg::GROUP_SIZE + k]) begin
					any_d[g]   = 1'b1;
					inner_d[g] = ffba_pkg::GRP_IDX_W'(k);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			any_q   <= any_d;
			inner_q <= inner_d;
		end
	end

	assign any   = any_q;
	assign inner = inner_q;

endmodule

// ===== hw/rtl/first_fit_block_allocator.sv =====
// First-fit allocator over a 64 KiB arena, tracked as an address-ordered table of up to
// 64 blocks held in a row of cells. Each request goes in turn through accept, a compare in
// every cell, a per-group first-match pick, a final pick of the first fitting or matching
// block, and an update in which every cell loads its new entry (split, append,
// merge or shift by one or two places from its neighbors). A new request is taken once
// the previous one has written its result; the result register lets the next request in
// while a result still waits. Status: 0 done, 1 ignored, 2 out of space.
module first_fit_block_allocator (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  ffba_pkg::req_t  req,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output ffba_pkg::rsp_t  rsp
);

	localparam int N = ffba_pkg::MAX_BLOCKS;

	ffba_pkg::state_t state_q, state_d;
	ffba_pkg::cell_ctl_t ctl;

	logic                          cmd_q;
	logic [ffba_pkg::TOP_W-1:0]    asize_q;
	logic                          zero_q;
	logic [15:0]                   addr_q;
	logic [ffba_pkg::CNT_W-1:0]    used_q;
	logic [ffba_pkg::TOP_W-1:0]    top_q;
	ffba_pkg::op_t                 op_s3;
	logic [ffba_pkg::IDX_W-1:0]    t_s3;
	logic                          split_s3, mleft_s3, mright_s3;
	logic [15:0]                   res_addr_s3;
	logic [1:0]                    status_s3;
	logic                          rsp_valid_q;
	ffba_pkg::rsp_t                rsp_q;

	ffba_pkg::entry_t ents [N];
	logic [N-1:0]     match_v, split_v;
	logic [ffba_pkg::NUM_GROUPS-1:0] g_any;
	logic [ffba_pkg::NUM_GROUPS-1:0][ffba_pkg::GRP_IDX_W-1:0] g_inner;

	logic                       apply_go;
	logic                       found;
	logic [ffba_pkg::IDX_W-1:0] t_d;
	ffba_pkg::op_t              op_d;
	logic                       split_d, mleft_d, mright_d;
	logic [15:0]                res_addr_d;
	logic [1:0]                 status_d;
	logic [ffba_pkg::CNT_W-1:0] used_d;
	logic [ffba_pkg::TOP_W:0]   room;

	assign apply_go = (state_q == ffba_pkg::S_APPLY) && !(rsp_valid_q && rsp_stall);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ffba_pkg::S_IDLE:  if (req_valid) state_d = ffba_pkg::S_MATCH;
			ffba_pkg::S_MATCH: state_d = ffba_pkg::S_GROUP;
			ffba_pkg::S_GROUP: state_d = ffba_pkg::S_PICK;
			ffba_pkg::S_PICK:  state_d = ffba_pkg::S_APPLY;
			ffba_pkg::S_APPLY: if (apply_go) state_d = ffba_pkg::S_IDLE;
			default:           state_d = ffba_pkg::S_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		req_stall = (state_q != ffba_pkg::S_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ffba_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// request capture, size rounded up to the alignment
	always_ff @(posedge clk) begin
		if (state_q == ffba_pkg::S_IDLE && req_valid) begin
			cmd_q   <= req.cmd;
			addr_q  <= req.free_address;
			zero_q  <= (req.req_size == 16'd0);
			asize_q <= (ffba_pkg::TOP_W'(req.req_size) + ffba_pkg::TOP_W'(ffba_pkg::ALIGN_BYTES - 1))
				& ~ffba_pkg::TOP_W'(ffba_pkg::ALIGN_BYTES - 1);
		end
	end

	assign ctl.match_en = (state_q == ffba_pkg::S_MATCH);
	assign ctl.apply_en = apply_go;
	assign ctl.cmd      = cmd_q;
	assign ctl.asize    = asize_q;
	assign ctl.addr     = addr_q;
	assign ctl.op       = op_s3;
	assign ctl.t        = t_s3;
	assign ctl.split    = split_s3;
	assign ctl.mleft    = mleft_s3;
	assign ctl.mright   = mright_s3;
	assign ctl.used     = used_q;
	assign ctl.top      = top_q;

	// row of cells, each seeing its neighbors
	for (genvar j = 0; j < N; j++) begin : g_cell
		ffba_pkg::entry_t lft, r1, r2;
		if (j > 0) begin : g_l
			assign lft = ents[j-1];
		end else begin : g_l0
			assign lft = '0;
		end
		if (j + 1 < N) begin : g_r1
			assign r1 = ents[j+1];
		end else begin : g_r1n
			assign r1 = '0;
		end
		if (j + 2 < N) begin : g_r2
			assign r2 = ents[j+2];
		end else begin : g_r2n
			assign r2 = '0;
		end
		ffba_cell u_cell (
			.clk    (clk),
			.idx    (ffba_pkg::IDX_W'(j)),
			.ctl    (ctl),
			.left   (lft),
			.right1 (r1),
			.right2 (r2),
			.ent    (ents[j]),
			.match  (match_v[j]),
			.split  (split_v[j])
		);
	end

	ffba_group u_group (
		.clk   (clk),
		.en    (state_q == ffba_pkg::S_GROUP),
		.flags (match_v),
		.any   (g_any),
		.inner (g_inner)
	);

	// pick the first group, then decide what the request does
	always_comb begin
		found      = 1'b0;
		t_d        = '0;
		op_d       = ffba_pkg::OP_NONE;
		split_d    = 1'b0;
		mleft_d    = 1'b0;
		mright_d   = 1'b0;
		res_addr_d = 16'd0;
		status_d   = ffba_pkg::STATUS_IGNORED;
		room       = (ffba_pkg::TOP_W+1)'(ffba_pkg::ARENA_BYTES) - {1'b0, top_q};
		for (int g = ffba_pkg::NUM_GROUPS - 1; g >= 0; g--) begin
			if (g_any[g]) begin
				found = 1'b1;
				t_d   = ffba_pkg::IDX_W'(g * ffba_pkg::GROUP_SIZE) + ffba_pkg::IDX_W'(g_inner[g]);
			end
		end
		if (cmd_q == ffba_pkg::CMD_ALLOC) begin
			if (zero_q) begin
				status_d = ffba_pkg::STATUS_IGNORED;
			end else if (found) begin
				op_d       = ffba_pkg::OP_FIT;
				split_d    = split_v[t_d] && (used_q < ffba_pkg::CNT_W'(N));
				res_addr_d = ents[t_d].off;
				status_d   = ffba_pkg::STATUS_DONE;
			end else if (used_q >= ffba_pkg::CNT_W'(N)
				|| top_q > ffba_pkg::TOP_W'(ffba_pkg::ARENA_BYTES)
				|| {1'b0, asize_q} > room) begin
				status_d = ffba_pkg::STATUS_NOSPACE;
			end else begin
				op_d       = ffba_pkg::OP_APPEND;
				res_addr_d = top_q[15:0];
				status_d   = ffba_pkg::STATUS_DONE;
			end
		end else begin
			if (addr_q != 16'd0 && found) begin
				op_d     = ffba_pkg::OP_FREE;
				status_d = ffba_pkg::STATUS_DONE;
				mleft_d  = (t_d != '0) && ents[t_d - 1'b1].fr;
				mright_d = (ffba_pkg::CNT_W'(t_d) + 1'b1 < used_q) && ents[t_d + 1'b1].fr;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s3 <= ffba_pkg::OP_NONE;
		end else if (state_q == ffba_pkg::S_PICK) begin
			op_s3 <= op_d;
		end else if (apply_go) begin
			op_s3 <= ffba_pkg::OP_NONE;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ffba_pkg::S_PICK) begin
			t_s3        <= t_d;
			split_s3    <= split_d;
			mleft_s3    <= mleft_d;
			mright_s3   <= mright_d;
			res_addr_s3 <= res_addr_d;
			status_s3   <= status_d;
		end
	end

	// block count after the update
	always_comb begin
		used_d = used_q;
		unique case (op_s3)
			ffba_pkg::OP_FIT:    used_d = used_q + ffba_pkg::CNT_W'(split_s3);
			ffba_pkg::OP_APPEND: used_d = used_q + 1'b1;
			ffba_pkg::OP_FREE:   used_d = used_q - ffba_pkg::CNT_W'(mleft_s3)
				- ffba_pkg::CNT_W'(mright_s3);
			default:             used_d = used_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q      <= '0;
			top_q       <= ffba_pkg::TOP_W'(ffba_pkg::HDR);
			rsp_valid_q <= 1'b0;
		end else begin
			if (apply_go) begin
				used_q <= used_d;
				if (op_s3 == ffba_pkg::OP_APPEND) begin
					top_q <= top_q + asize_q + ffba_pkg::TOP_W'(ffba_pkg::HDR);
				end
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (apply_go) begin
			rsp_q.data_address <= res_addr_s3;
			rsp_q.status       <= status_s3;
			rsp_q.block_count  <= 7'(used_d);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef SYNTHESIS
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= ffba_pkg::CNT_W'(N))
		else $error("block count above table size");

	a_apply_result: assert property (@(posedge clk) disable iff (!arst_n)
		apply_go |=> rsp_valid && state_q == ffba_pkg::S_IDLE)
		else $error("update without result");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.status != 2'd3)
		else $error("bad status code");

	a_top_floor: assert property (@(posedge clk) disable iff (!arst_n)
		top_q >= ffba_pkg::TOP_W'(ffba_pkg::HDR))
		else $error("arena top below first header");
`endif

endmodule

// ===== sim/ffba_checker.sv =====
`timescale 1ns / 100ps

// Watches both channels, keeps a shadow block table and compares every result.
module ffba_checker (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	input  logic            req_stall,
	input  ffba_pkg::req_t  req,
	input  logic            rsp_valid,
	input  logic            rsp_stall,
	input  ffba_pkg::rsp_t  rsp,
	output int              fail_count,
	output int              pending_count,
	output logic            accepted
);

	// shadow table
	logic [15:0] tbl_off [ffba_pkg::MAX_BLOCKS];
	logic [15:0] tbl_sz [ffba_pkg::MAX_BLOCKS];
	logic        tbl_fr [ffba_pkg::MAX_BLOCKS];
	int unsigned tbl_used;
	int unsigned tbl_top;

	ffba_pkg::rsp_t expected_rsp_q[$];

	function automatic void drop_block(int unsigned k);
		for (int unsigned j = k; j + 1 < tbl_used; j++) begin
			tbl_off[j] = tbl_off[j+1];
			tbl_sz[j]  = tbl_sz[j+1];
			tbl_fr[j]  = tbl_fr[j+1];
		end
		tbl_used--;
	endfunction

	function automatic void open_block(int unsigned k);
		for (int unsigned j = tbl_used; j > k; j--) begin
			tbl_off[j] = tbl_off[j-1];
			tbl_sz[j]  = tbl_sz[j-1];
			tbl_fr[j]  = tbl_fr[j-1];
		end
		tbl_used++;
	endfunction

	// first fit with split, else append at the top
	function automatic void alloc_block(int unsigned size, output logic [15:0] addr,
			output logic [1:0] st);
		int unsigned asize;
		addr = '0;
		if (size == 0) begin
			st = ffba_pkg::STATUS_IGNORED;
			return;
		end
		asize = (size + ffba_pkg::ALIGN_BYTES - 1) / ffba_pkg::ALIGN_BYTES
			* ffba_pkg::ALIGN_BYTES;
		for (int unsigned i = 0; i < tbl_used; i++) begin
			if (tbl_fr[i] && tbl_sz[i] >= asize) begin
				if (tbl_sz[i] >= asize + ffba_pkg::HDR + ffba_pkg::ALIGN_BYTES
						&& tbl_used < ffba_pkg::MAX_BLOCKS) begin
					open_block(i + 1);
					tbl_off[i+1] = 16'(tbl_off[i] + asize + ffba_pkg::HDR);
					tbl_sz[i+1]  = 16'(tbl_sz[i] - asize - ffba_pkg::HDR);
					tbl_fr[i+1]  = 1'b1;
					tbl_sz[i]    = 16'(asize);
				end
				tbl_fr[i] = 1'b0;
				st = ffba_pkg::STATUS_DONE;
				addr = tbl_off[i];
				return;
			end
		end
		if (tbl_used >= ffba_pkg::MAX_BLOCKS || tbl_top > ffba_pkg::ARENA_BYTES
				|| asize > ffba_pkg::ARENA_BYTES - tbl_top) begin
			st = ffba_pkg::STATUS_NOSPACE;
			return;
		end
		addr = tbl_top[15:0];
		tbl_off[tbl_used] = tbl_top[15:0];
		tbl_sz[tbl_used]  = 16'(asize);
		tbl_fr[tbl_used]  = 1'b0;
		tbl_used++;
		tbl_top = tbl_top + asize + ffba_pkg::HDR;
		st = ffba_pkg::STATUS_DONE;
	endfunction

	// mark free and merge with free neighbors
	function automatic logic [1:0] free_block(logic [15:0] addr);
		int unsigned i;
		if (addr == 0) return ffba_pkg::STATUS_IGNORED;
		for (i = 0; i < tbl_used; i++)
			if (tbl_off[i] == addr) break;
		if (i >= tbl_used) return ffba_pkg::STATUS_IGNORED;
		if (i > 0 && tbl_fr[i-1]) begin
			tbl_sz[i-1] = 16'(tbl_sz[i-1] + tbl_sz[i] + ffba_pkg::HDR);
			drop_block(i);
			i--;
		end
		if (i + 1 < tbl_used && tbl_fr[i+1]) begin
			tbl_sz[i] = 16'(tbl_sz[i] + tbl_sz[i+1] + ffba_pkg::HDR);
			drop_block(i + 1);
		end
		tbl_fr[i] = 1'b1;
		return ffba_pkg::STATUS_DONE;
	endfunction

	assign pending_count = expected_rsp_q.size();
	assign accepted = (req_valid && !req_stall) || (rsp_valid && !rsp_stall);

	always @(posedge clk or negedge arst_n) begin
		ffba_pkg::rsp_t exp_rsp;
		int errs;
		if (!arst_n) begin
			tbl_used = 0;
			tbl_top  = ffba_pkg::HDR;
			fail_count <= 0;
			expected_rsp_q.delete();
		end else begin
			errs = 0;
			// compare first: a result never comes out in the cycle its request is taken
			if (rsp_valid && !rsp_stall) begin
				if (expected_rsp_q.size() == 0) begin
					$error("result with nothing expected: %p", rsp);
					errs++;
				end else begin
					exp_rsp = expected_rsp_q.pop_front();
					if (rsp.data_address !== exp_rsp.data_address) begin
						$error("data_address: expected %0d, got %0d",
							exp_rsp.data_address, rsp.data_address);
						errs++;
					end
					if (rsp.status !== exp_rsp.status) begin
						$error("status: expected %0d, got %0d", exp_rsp.status, rsp.status);
						errs++;
					end
					if (rsp.block_count !== exp_rsp.block_count) begin
						$error("block_count: expected %0d, got %0d",
							exp_rsp.block_count, rsp.block_count);
						errs++;
					end
				end
			end
			if (req_valid && !req_stall) begin
				exp_rsp = '0;
				if (req.cmd == ffba_pkg::CMD_ALLOC)
					alloc_block(req.req_size, exp_rsp.data_address, exp_rsp.status);
				else
					exp_rsp.status = free_block(req.free_address);
				exp_rsp.block_count = tbl_used[6:0];
				expected_rsp_q.push_back(exp_rsp);
			end
			fail_count <= fail_count + errs;
		end
	end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps

module tb;

	localparam int RANDOM_ITEMS = 1130;
	localparam int IDLE_LIMIT   = 20000;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	ffba_pkg::req_t req;
	logic rsp_valid;
	logic rsp_stall;
	ffba_pkg::rsp_t rsp;
	int   fail_count;
	int   pending_count;
	logic accepted;
	int   idle_cycles;
	bit   hold_off;

	// addresses handed out, kept as free targets
	logic [15:0] live_addr_q[$];

	first_fit_block_allocator u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	ffba_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (req_valid),
		.req_stall     (req_stall),
		.req           (req),
		.rsp_valid     (rsp_valid),
		.rsp_stall     (rsp_stall),
		.rsp           (rsp),
		.fail_count    (fail_count),
		.pending_count (pending_count),
		.accepted      (accepted)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic int gap_len();
		if ($urandom_range(9) < 6) return 0;
		if ($urandom_range(9) < 9) return $urandom_range(3);
		return $urandom_range(40, 10);
	endfunction

	// offer one item and hold it until taken
	task automatic send_item(logic cmd, logic [15:0] size, logic [15:0] addr);
		int gap;
		gap = gap_len();
		repeat (gap) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid        <= 1'b1;
		req.cmd          <= cmd;
		req.req_size     <= size;
		req.free_address <= addr;
		@(posedge clk);
		while (req_stall) @(posedge clk);
	endtask

	// learn live addresses from the result stream
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall && rsp.status == ffba_pkg::STATUS_DONE
				&& rsp.data_address != 0)
			live_addr_q.push_back(rsp.data_address);
	end

	// receiver stalls, with one long hold-off on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall <= 1'b1;
		end else if (hold_off) begin
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= ($urandom_range(9) < 3);
		end
	end

	initial begin
		hold_off = 1'b0;
		@(posedge arst_n);
		repeat (300) @(posedge clk);
		hold_off <= 1'b1;
		repeat (200) @(posedge clk);
		hold_off <= 1'b0;
	end

	// watchdog
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= accepted ? 0 : idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("tb: done, errors");
				$finish;
			end
		end
	end

	initial begin
		int    pick;
		int    end_wait;
		logic [15:0] target;
		arst_n    = 1'b0;
		req_valid = 1'b0;
		req       = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: ignored cases, alignment, split, merge, double free, full arena
		send_item(ffba_pkg::CMD_ALLOC, 16'd0, 16'hFFFF);
		send_item(ffba_pkg::CMD_FREE, 16'hFFFF, 16'd0);
		send_item(ffba_pkg::CMD_FREE, 16'd0, 16'd12345);
		send_item(ffba_pkg::CMD_ALLOC, 16'd1, 16'd0);
		send_item(ffba_pkg::CMD_ALLOC, 16'd200, 16'd0);
		send_item(ffba_pkg::CMD_ALLOC, 16'd8, 16'd0);
		send_item(ffba_pkg::CMD_ALLOC, 16'd17, 16'd0);
		send_item(ffba_pkg::CMD_FREE, 16'd0, 16'(ffba_pkg::HDR + 8 + ffba_pkg::HDR));
		send_item(ffba_pkg::CMD_ALLOC, 16'd24, 16'd0);
		send_item(ffba_pkg::CMD_FREE, 16'd0, 16'(ffba_pkg::HDR + 8 + ffba_pkg::HDR));
		send_item(ffba_pkg::CMD_FREE, 16'd0, 16'(ffba_pkg::HDR + 8 + ffba_pkg::HDR));
		send_item(ffba_pkg::CMD_FREE, 16'd0, 16'(ffba_pkg::HDR));
		send_item(ffba_pkg::CMD_ALLOC, 16'd210, 16'd0);
		send_item(ffba_pkg::CMD_ALLOC, 16'hFFFF, 16'd0);
		send_item(ffba_pkg::CMD_ALLOC, 16'd65000, 16'd0);
		send_item(ffba_pkg::CMD_ALLOC, 16'd65000, 16'd0);
		send_item(ffba_pkg::CMD_FREE, 16'd0, 16'hFFFF);
		send_item(ffba_pkg::CMD_ALLOC, 16'd32768, 16'd0);
		// free every address that was handed out so far
		while (live_addr_q.size() != 0) begin
			target = live_addr_q.pop_front();
			send_item(ffba_pkg::CMD_FREE, 16'($urandom), target);
		end

		// random: mostly small allocs and frees of live blocks, a few large and bogus
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			pick = $urandom_range(99);
			if (pick < 45) begin
				send_item(ffba_pkg::CMD_ALLOC, ($urandom_range(99) < 90)
					? 16'($urandom_range(300, 1)) : 16'($urandom), 16'($urandom));
			end else if (pick < 85 && live_addr_q.size() != 0) begin
				target = live_addr_q[$urandom_range(live_addr_q.size() - 1)];
				send_item(ffba_pkg::CMD_FREE, 16'($urandom), target);
			end else if (pick < 93) begin
				send_item(ffba_pkg::CMD_FREE, 16'($urandom), 16'($urandom));
			end else begin
				send_item(ffba_pkg::CMD_ALLOC, ($urandom_range(1) != 0) ? 16'd0
					: 16'($urandom), 16'($urandom));
			end
		end
		req_valid <= 1'b0;

		// drain, then let the block settle
		end_wait = 0;
		while (pending_count != 0 && end_wait < IDLE_LIMIT) begin
			@(posedge clk);
			end_wait++;
		end
		repeat (20) @(posedge clk);
		if (fail_count == 0 && pending_count == 0) begin
			$display("tb: done, clean");
		end else begin
			$display("tb: done, errors");
		end
		$finish;
	end

endmodule
